// ----- rtl/rnfm_pkg.sv -----
// Shared constants, request type and helpers for the radius neighbour mean block
`timescale 1ns / 1ps
package rnfm_pkg;

	localparam int MAX_POINTS         = 256;
	localparam int FEATURES_PER_POINT = 230;
	localparam int FEAT_DEPTH         = MAX_POINTS * FEATURES_PER_POINT;
	localparam int PT_W               = 8;
	localparam int FI_W               = 8;
	localparam int FADDR_W            = $clog2(FEAT_DEPTH);
	localparam int COORD_W            = 24;
	localparam int VAL_W              = 32;
	localparam int PCNT_W             = 9;
	localparam int RAD_W              = 23;
	localparam int CFG_IDX_W          = 1;
	localparam int CFG_DATA_W         = 23;
	localparam int CNT_W              = 8;
	localparam int SUM_W              = VAL_W + CNT_W;
	localparam int NUM_W              = SUM_W + 1;
	localparam int DEN_W              = CNT_W + 1;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(25600);

	localparam logic [1:0] OP_LOAD_COORD = 2'd0;
	localparam logic [1:0] OP_LOAD_FEAT  = 2'd1;
	localparam logic [1:0] OP_QUERY      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'd1;

	typedef enum logic [1:0] {
		K_COORD = 2'd0,
		K_FEAT  = 2'd1,
		K_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [PT_W-1:0]     point;
		logic [FI_W-1:0]     feature;
		logic                feat_ok;
		logic [VAL_W-1:0]    value;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
	} req_t;

	function automatic logic [FADDR_W-1:0] feat_addr(logic [PT_W-1:0] p, logic [FI_W-1:0] f);
		return FADDR_W'(p * FEATURES_PER_POINT) + FADDR_W'(f);
	endfunction

endpackage

// ----- rtl/rnfm_ram.sv -----
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
module rnfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/rnfm_front.sv -----
// Request intake: classify, drop meaningless requests, two-entry queue to the engine
`timescale 1ns / 1ps
module rnfm_front import rnfm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [PT_W-1:0]    point_index,
	input  logic [FI_W-1:0]    feature_index,
	input  logic [VAL_W-1:0]   value,
	input  logic [COORD_W-1:0] x_coord,
	input  logic [COORD_W-1:0] y_coord,
	output req_t               head,
	output logic               head_valid,
	input  logic               pop
);

	req_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	req_t       req;
	logic       keep, push;

	always_comb begin
		req.point   = point_index;
		req.feature = feature_index;
		req.feat_ok = 32'(feature_index) < FEATURES_PER_POINT;
		req.value   = value;
		req.x       = x_coord;
		req.y       = y_coord;
		req.kind    = K_QUERY;
		keep        = 1'b0;
		case (operation)
			OP_LOAD_COORD: begin
				req.kind = K_COORD;
				keep     = 1'b1;
			end
			OP_LOAD_FEAT: begin
				req.kind = K_FEAT;
				keep     = req.feat_ok;
			end
			OP_QUERY: begin
				req.kind = K_QUERY;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign busy       = fill_q == 2'd2;
	assign push       = start && !busy && keep;
	assign head       = slot_q[rd_ptr_q];
	assign head_valid = fill_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- rtl/rnfm_back.sv -----
// Execution engine: store writes, neighbour walk pipeline and serial rounding divider
`timescale 1ns / 1ps
module rnfm_back import rnfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  req_t                head,
	input  logic                head_valid,
	output logic                pop,
	input  logic [PCNT_W-1:0]   point_count,
	input  logic [RAD_W-1:0]    radius,
	output logic                done,
	output logic [PT_W-1:0]     point_id,
	output logic [FI_W-1:0]     feature_id,
	output logic [VAL_W-1:0]    own_value,
	output logic [VAL_W-1:0]    neighbor_mean,
	output logic [CNT_W-1:0]    neighbor_count
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_OWN  = 5'b00010,
		S_WALK = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t               state_q;
	logic [PT_W-1:0]      pt_q;
	logic [FI_W-1:0]      fi_q;
	logic                 fok_q;
	logic [COORD_W-1:0]   own_x_q, own_y_q;
	logic [VAL_W-1:0]     own_val_q;
	logic [2*RAD_W-1:0]   r2_q;
	logic [PCNT_W-1:0]    limit_q, j_q;
	logic [FADDR_W-1:0]   faddr_q;
	logic                 v_s1, v_s2, v_s3;
	logic [COORD_W-1:0]   dx_s2, dy_s2;
	logic [VAL_W-1:0]     f_s2, f_s3;
	logic [2*COORD_W-1:0] sqx_s3, sqy_s3;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     rem_q;
	logic [VAL_W-1:0]     quo_q;
	logic [5:0]           step_q;
	logic                 neg_q;

	logic [2*COORD_W-1:0] c_rd;
	logic [VAL_W-1:0]     f_rd;
	logic                 coord_we, feat_we, issue, walk_end;
	logic [PT_W-1:0]      coord_raddr;
	logic [FADDR_W-1:0]   feat_raddr, feat_waddr;
	logic [COORD_W:0]     dx, dy;
	logic [COORD_W-1:0]   mx, my;
	logic [SUM_W-1:0]     sum_mag;
	logic [DEN_W:0]       trial;
	logic [DEN_W-1:0]     den;

	assign coord_we   = state_q == S_IDLE && head_valid && head.kind == K_COORD;
	assign feat_we    = state_q == S_IDLE && head_valid && head.kind == K_FEAT;
	assign pop        = state_q == S_IDLE && head_valid;
	assign feat_waddr = feat_addr(head.point, head.feature);
	assign issue      = state_q == S_WALK && j_q < limit_q;
	assign walk_end   = state_q == S_WALK && !issue && !v_s1 && !v_s2 && !v_s3;
	assign coord_raddr = state_q == S_IDLE ? head.point : j_q[PT_W-1:0];
	assign feat_raddr  = state_q == S_IDLE ? feat_waddr : faddr_q;

	rnfm_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_coord (
		.clk(clk), .we(coord_we), .waddr(head.point), .wdata({head.x, head.y}),
		.raddr(coord_raddr), .rdata(c_rd)
	);

	rnfm_ram #(.WIDTH(VAL_W), .DEPTH(FEAT_DEPTH)) u_feat (
		.clk(clk), .we(feat_we), .waddr(feat_waddr), .wdata(head.value),
		.raddr(feat_raddr), .rdata(f_rd)
	);

	// distance magnitudes of the walked point against the queried one
	always_comb begin
		dx = {own_x_q[COORD_W-1], own_x_q} - {c_rd[2*COORD_W-1], c_rd[2*COORD_W-1:COORD_W]};
		dy = {own_y_q[COORD_W-1], own_y_q} - {c_rd[COORD_W-1], c_rd[COORD_W-1:0]};
		mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
	end

	assign sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign den     = {count_q, 1'b0};
	assign trial   = {rem_q, num_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		dx_s2  <= mx;
		dy_s2  <= my;
		f_s2   <= fok_q ? f_rd : '0;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		f_s3   <= f_s2;
		case (state_q)
			S_IDLE: begin
				pt_q  <= head.point;
				fi_q  <= head.feature;
				fok_q <= head.feat_ok;
			end
			S_OWN: begin
				own_x_q   <= c_rd[2*COORD_W-1:COORD_W];
				own_y_q   <= c_rd[COORD_W-1:0];
				own_val_q <= fok_q ? f_rd : '0;
				r2_q      <= radius * radius;
				limit_q   <= point_count > PCNT_W'(MAX_POINTS) ? PCNT_W'(MAX_POINTS) : point_count;
				j_q       <= '0;
				faddr_q   <= FADDR_W'(fi_q);
				count_q   <= '0;
				sum_q     <= '0;
			end
			S_WALK: begin
				if (issue) begin
					j_q     <= j_q + 1'b1;
					faddr_q <= faddr_q + FADDR_W'(FEATURES_PER_POINT);
				end
				if (v_s3 && {1'b0, sqx_s3} + {1'b0, sqy_s3} <= (2*COORD_W+1)'(r2_q)) begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + {{CNT_W{f_s3[VAL_W-1]}}, f_s3};
				end
				if (walk_end) begin
					num_q  <= {sum_mag, 1'b0} + NUM_W'(count_q);
					neg_q  <= sum_q[SUM_W-1];
					rem_q  <= '0;
					quo_q  <= '0;
					step_q <= 6'(NUM_W - 1);
				end
			end
			S_DIV: begin
				// one restoring step per cycle on (2|sum| + n) / 2n
				if (trial >= {1'b0, den}) begin
					rem_q <= DEN_W'(trial - {1'b0, den});
					quo_q <= {quo_q[VAL_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DEN_W-1:0];
					quo_q <= {quo_q[VAL_W-2:0], 1'b0};
				end
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
		// take the quotient once the last divider step has landed
		if (state_q == S_DONE) begin
			neighbor_mean <= count_q == '0 ? '0 : (neg_q ? -quo_q : quo_q);
		end
		point_id       <= pt_q;
		feature_id     <= fi_q;
		own_value      <= own_val_q;
		neighbor_count <= count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			done    <= 1'b0;
		end else begin
			v_s1 <= issue && j_q[PT_W-1:0] != pt_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (head_valid && head.kind == K_QUERY) state_q <= S_OWN;
				S_OWN:  state_q <= S_WALK;
				S_WALK: if (walk_end) state_q <= count_q == '0 ? S_DONE : S_DIV;
				S_DIV:  if (step_q == '0) state_q <= S_DONE;
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/radius_neighbor_feature_mean_core.sv -----
// Top level: configuration registers, request front end and execution engine
//
// channel   direction  handshake        payload
// request   in         start & !busy    operation, point_index, feature_index, value,
//                                       x_coord, y_coord
// result    out        done (1 cycle)   point_id, feature_id, own_value, neighbor_mean,
//                                       neighbor_count
// config    in         cfg_we           cfg_index, cfg_data
//
// Loads are written to the stores from the idle state. A query strobes its result after walking
// limit points (one point per cycle through the coordinate and feature RAM read ports, three
// stage distance pipeline) and, when neighbours are found, the bit-serial divider.
// Two requests queue in front of the engine; busy rises while the queue is full.
// Reset clears control state and point count and sets radius to 25600; store contents are undefined until loaded.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module radius_neighbor_feature_mean_core import rnfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            operation,
	input  logic [PT_W-1:0]       point_index,
	input  logic [FI_W-1:0]       feature_index,
	input  logic signed [VAL_W-1:0]   value,
	input  logic signed [COORD_W-1:0] x_coord,
	input  logic signed [COORD_W-1:0] y_coord,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [PT_W-1:0]       point_id,
	output logic [FI_W-1:0]       feature_id,
	output logic signed [VAL_W-1:0] own_value,
	output logic signed [VAL_W-1:0] neighbor_mean,
	output logic [CNT_W-1:0]      neighbor_count
);

	logic [PCNT_W-1:0] point_count_q;
	logic [RAD_W-1:0]  radius_q;
	req_t              head;
	logic              head_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			radius_q      <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[PCNT_W-1:0];
				REG_RADIUS:      radius_q      <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	rnfm_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .point_index(point_index), .feature_index(feature_index),
		.value(value), .x_coord(x_coord), .y_coord(y_coord),
		.head(head), .head_valid(head_valid), .pop(pop)
	);

	rnfm_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid), .pop(pop),
		.point_count(point_count_q), .radius(radius_q),
		.done(done), .point_id(point_id), .feature_id(feature_id),
		.own_value(own_value), .neighbor_mean(neighbor_mean),
		.neighbor_count(neighbor_count)
	);

endmodule

// ----- rtl/rnfm_checker.sv -----
// Port-level checks on the result strobe and result fields, bound to the top level
`timescale 1ns / 1ps
module rnfm_checker import rnfm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              done,
	input logic [FI_W-1:0]   feature_id,
	input logic [VAL_W-1:0]  own_value,
	input logic [VAL_W-1:0]  neighbor_mean,
	input logic [CNT_W-1:0]  neighbor_count
);

	// a query never finishes in back-to-back cycles
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for two cycles");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		done && neighbor_count == '0 |-> neighbor_mean == '0)
		else $error("non-zero mean without neighbours");

	a_bad_feature: assert property (@(posedge clk) disable iff (!arst_n)
		done && 32'(feature_id) >= FEATURES_PER_POINT |-> own_value == '0 && neighbor_mean == '0)
		else $error("feature outside the row read non-zero");

	a_no_result_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done) else $error("result straight out of reset");

endmodule

bind radius_neighbor_feature_mean_core rnfm_checker u_rnfm_checker (
	.clk(clk), .arst_n(arst_n), .done(done), .feature_id(feature_id),
	.own_value(own_value), .neighbor_mean(neighbor_mean), .neighbor_count(neighbor_count)
);

// ----- tb/sv/rnfm_scoreboard.sv -----
// Checker for the radius neighbour mean block: predicts query results and compares them
`timescale 1ns / 1ps
module rnfm_scoreboard import rnfm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [1:0]                operation,
	input  logic [PT_W-1:0]           point_index,
	input  logic [FI_W-1:0]           feature_index,
	input  logic signed [VAL_W-1:0]   value,
	input  logic signed [COORD_W-1:0] x_coord,
	input  logic signed [COORD_W-1:0] y_coord,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      done,
	input  logic [PT_W-1:0]           point_id,
	input  logic [FI_W-1:0]           feature_id,
	input  logic signed [VAL_W-1:0]   own_value,
	input  logic signed [VAL_W-1:0]   neighbor_mean,
	input  logic [CNT_W-1:0]          neighbor_count,
	output int                        fail_count,
	output int                        pending
);

	typedef struct {
		logic [PT_W-1:0]  point;
		logic [FI_W-1:0]  feature;
		logic [VAL_W-1:0] own;
		logic [VAL_W-1:0] mean;
		logic [CNT_W-1:0] count;
	} mean_result_t;

	logic signed [COORD_W-1:0] pos_x [MAX_POINTS];
	logic signed [COORD_W-1:0] pos_y [MAX_POINTS];
	logic signed [VAL_W-1:0]   feat_store [FEAT_DEPTH];
	logic [PCNT_W-1:0]         active_points;
	logic [RAD_W-1:0]          limit_radius;
	mean_result_t              expected_means [$];

	function automatic longint feat_of(int p, int f);
		if (f >= FEATURES_PER_POINT)
			return 0;
		return longint'(feat_store[p * FEATURES_PER_POINT + f]);
	endfunction

	function automatic mean_result_t neighbour_mean(logic [PT_W-1:0] p, logic [FI_W-1:0] f);
		mean_result_t r;
		int      lim;
		int      n;
		longint  dx;
		longint  dy;
		longint  r2;
		longint  acc;
		longint  mag;
		longint  q;
		lim = (active_points > MAX_POINTS) ? MAX_POINTS : int'(active_points);
		r2  = longint'(limit_radius) * longint'(limit_radius);
		n   = 0;
		acc = 0;
		for (int j = 0; j < lim; j++) begin
			if (j == int'(p))
				continue;
			dx = longint'(pos_x[p]) - longint'(pos_x[j]);
			dy = longint'(pos_y[p]) - longint'(pos_y[j]);
			if (dx * dx + dy * dy <= r2) begin
				n++;
				acc += feat_of(j, f);
			end
		end
		q = 0;
		if (n > 0) begin
			mag = (acc < 0) ? -acc : acc;
			q   = (2 * mag + n) / (2 * n);
			if (acc < 0)
				q = -q;
		end
		r.point   = p;
		r.feature = f;
		r.own     = VAL_W'(feat_of(p, f));
		r.mean    = VAL_W'(q);
		r.count   = (n > 255) ? 8'd255 : CNT_W'(n);
		return r;
	endfunction

	assign pending = expected_means.size();

	always @(posedge clk or negedge arst_n) begin
		mean_result_t e;
		if (!arst_n) begin
			active_points <= '0;
			limit_radius  <= RADIUS_RESET;
			fail_count    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POINT_COUNT: active_points <= cfg_data[PCNT_W-1:0];
					REG_RADIUS:      limit_radius  <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (operation)
					OP_LOAD_COORD: begin
						pos_x[point_index] = x_coord;
						pos_y[point_index] = y_coord;
					end
					OP_LOAD_FEAT: begin
						if (feature_index < FEATURES_PER_POINT)
							feat_store[point_index * FEATURES_PER_POINT + feature_index] = value;
					end
					OP_QUERY: expected_means = {expected_means,
						neighbour_mean(point_index, feature_index)};
					default: ;
				endcase
			end
			if (done) begin
				if (expected_means.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result: point %0d feature %0d", point_id, feature_id);
				end else begin
					e = expected_means.pop_front();
					if (e.point !== point_id || e.feature !== feature_id || e.own !== own_value
							|| e.mean !== neighbor_mean || e.count !== neighbor_count) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp p%0d f%0d own %h mean %h cnt %0d, got p%0d f%0d own %h mean %h cnt %0d",
								e.point, e.feature, e.own, e.mean, e.count, point_id, feature_id,
								own_value, neighbor_mean, neighbor_count);
					end
				end
			end
		end
	end

endmodule

// ----- tb/sv/tb_radius_neighbor_feature_mean_core.sv -----
// Stimulus and verdict for the radius neighbour mean block
`timescale 1ns / 1ps
module tb_radius_neighbor_feature_mean_core;
	import rnfm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 600;
	// feature column loaded for every point, so queries never read an unwritten entry
	localparam logic [FI_W-1:0] QUERY_FEAT = 8'd229;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                operation;
	logic [PT_W-1:0]           point_index;
	logic [FI_W-1:0]           feature_index;
	logic signed [VAL_W-1:0]   value;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      done;
	logic [PT_W-1:0]           point_id;
	logic [FI_W-1:0]           feature_id;
	logic signed [VAL_W-1:0]   own_value;
	logic signed [VAL_W-1:0]   neighbor_mean;
	logic [CNT_W-1:0]          neighbor_count;
	int                        fail_count;
	int                        pending;
	int                        quiet_cycles;
	bit                        gaps_on;

	radius_neighbor_feature_mean_core uut (.*);

	rnfm_scoreboard checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_radius_neighbor_feature_mean_core failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(logic [1:0] op, logic [PT_W-1:0] p, logic [FI_W-1:0] f,
			logic [VAL_W-1:0] v, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start         <= 1'b1;
		operation     <= op;
		point_index   <= p;
		feature_index <= f;
		value         <= v;
		x_coord       <= x;
		y_coord       <= y;
		do @(posedge clk); while (busy);
	endtask

	// drain outstanding queries, then write both registers
	task automatic set_regs(int unsigned pts, int unsigned rad);
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POINT_COUNT;
		cfg_data  <= CFG_DATA_W'(pts);
		@(posedge clk);
		cfg_index <= REG_RADIUS;
		cfg_data  <= CFG_DATA_W'(rad);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return COORD_W'($urandom);
			1:       return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
			default: return COORD_W'(int'($urandom_range(0, 80000)) - 40000);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
			1:       return VAL_W'(int'($urandom_range(0, 200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FI_W-1:0] query_feat();
		if ($urandom_range(0, 6) == 0)
			return FI_W'($urandom_range(FEATURES_PER_POINT, 255));
		return QUERY_FEAT;
	endfunction

	task automatic random_phase(int n);
		int unsigned r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				send_request(OP_LOAD_COORD, PT_W'($urandom), FI_W'($urandom), $urandom,
					pick_coord(), pick_coord());
			else if (r < 50)
				send_request(OP_LOAD_FEAT, PT_W'($urandom),
					($urandom_range(0, 4) == 0) ? FI_W'($urandom) : QUERY_FEAT,
					pick_value(), COORD_W'($urandom), COORD_W'($urandom));
			else if (r < 95)
				send_request(OP_QUERY, PT_W'($urandom), query_feat(), $urandom,
					COORD_W'($urandom), COORD_W'($urandom));
			else
				send_request(OP_UNUSED, PT_W'($urandom), FI_W'($urandom), $urandom,
					COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		operation     = OP_LOAD_COORD;
		point_index   = '0;
		feature_index = '0;
		value         = '0;
		x_coord       = '0;
		y_coord       = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_POINT_COUNT;
		cfg_data      = '0;
		gaps_on       = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every coordinate and the queried feature column
		for (int p = 0; p < MAX_POINTS; p++)
			send_request(OP_LOAD_COORD, PT_W'(p), FI_W'($urandom), $urandom,
				pick_coord(), pick_coord());
		for (int p = 0; p < MAX_POINTS; p++)
			send_request(OP_LOAD_FEAT, PT_W'(p), QUERY_FEAT, pick_value(),
				COORD_W'($urandom), COORD_W'($urandom));

		// no points taking part, default radius
		send_request(OP_QUERY, 8'd5, QUERY_FEAT, '0, '0, '0);

		set_regs(MAX_POINTS, 23'h7FFFFF);
		send_request(OP_LOAD_COORD, 8'd0, 8'd0, '0, 24'h800000, 24'h800000);
		send_request(OP_LOAD_COORD, 8'd1, 8'd0, '0, 24'h7FFFFF, 24'h7FFFFF);
		send_request(OP_LOAD_FEAT, 8'd0, QUERY_FEAT, 32'h80000000, '0, '0);
		send_request(OP_LOAD_FEAT, 8'd1, QUERY_FEAT, 32'h7FFFFFFF, '0, '0);
		send_request(OP_LOAD_FEAT, 8'd2, 8'd250, 32'h12345678, '0, '0);
		send_request(OP_UNUSED, 8'd3, 8'd0, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_request(OP_QUERY, 8'd0, QUERY_FEAT, '0, '0, '0);
		send_request(OP_QUERY, 8'd1, QUERY_FEAT, '0, '0, '0);
		send_request(OP_QUERY, 8'd200, 8'd230, '0, '0, '0);
		send_request(OP_QUERY, 8'd255, 8'd255, '0, '0, '0);

		// zero radius: only coincident points count
		set_regs(9'd511, 0);
		send_request(OP_LOAD_COORD, 8'd2, 8'd0, '0, 24'h000100, 24'hFFFF00);
		send_request(OP_LOAD_COORD, 8'd3, 8'd0, '0, 24'h000100, 24'hFFFF00);
		send_request(OP_QUERY, 8'd2, QUERY_FEAT, '0, '0, '0);
		send_request(OP_QUERY, 8'd3, 8'd240, '0, '0, '0);

		set_regs(MAX_POINTS, 25600);
		random_phase(40);
		set_regs(0, 25600);
		random_phase(40);
		set_regs(9'd511, 0);
		random_phase(40);
		set_regs(40, 23'h7FFFFF);
		random_phase(40);
		set_regs(300, 30000);
		random_phase(55);
		set_regs(17, 12345);
		random_phase(55);
		set_regs(MAX_POINTS, 23'h7FFFFF);
		gaps_on = 1'b0;
		random_phase(55);

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_radius_neighbor_feature_mean_core passed");
		else
			$display("tb_radius_neighbor_feature_mean_core failed");
		$finish;
	end

endmodule
